FILE: hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Threshold peak statistics package
// Shared widths, request and result types for the peak statistics block.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COUNT_W     = 32;
	localparam int ACC_W       = 56;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] injection;
		logic signed [SAMPLE_W-1:0] dissipation;
		logic                       last;
	} in_item_t;

	typedef struct packed {
		logic        [COUNT_W-1:0] sample_count;
		logic        [COUNT_W-1:0] peak_count;
		logic signed [ACC_W-1:0]   injection_sum;
		logic signed [ACC_W-1:0]   dissipation_sum;
		logic signed [ACC_W-1:0]   peak_max_sum;
		logic        [COUNT_W-1:0] peak_length_sum;
		logic        [COUNT_W-1:0] peak_gap_sum;
		logic                      still_in_peak;
	} out_item_t;

	typedef struct packed {
		in_item_t item;
		logic     above;
		logic     below;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: hw/rtl/tsp_front.sv
// ----------------------------------------------------------------------------
// Threshold peak statistics front end
// Holds the threshold register, accepts requests and classifies each sample
// against the threshold before it enters the queue.
// ----------------------------------------------------------------------------
module tsp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic signed [tsp_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tsp_pkg::in_item_t               in_data,
	input  tsp_pkg::q_status_t              q_status,
	output logic                            push,
	output tsp_pkg::q_entry_t               push_data
);
	import tsp_pkg::*;

	logic signed [SAMPLE_W-1:0] threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	assign in_stall        = q_status.full;
	assign push            = in_valid && !q_status.full;
	assign push_data.item  = in_data;
	assign push_data.above = in_data.dissipation > threshold_q;
	assign push_data.below = in_data.dissipation < threshold_q;

endmodule

FILE: hw/rtl/tsp_queue.sv
// ----------------------------------------------------------------------------
// Threshold peak statistics queue
// Short first-in first-out queue of classified requests between the front
// end and the statistics back end.
// ----------------------------------------------------------------------------
module tsp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsp_pkg::q_entry_t  push_data,
	input  logic               pop,
	output tsp_pkg::q_entry_t  head,
	output tsp_pkg::q_status_t status
);
	import tsp_pkg::*;

	q_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;

endmodule

FILE: hw/rtl/tsp_back.sv
// ----------------------------------------------------------------------------
// Threshold peak statistics back end
// Tracks peaks, accumulates the record statistics and holds the result in an
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tsp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tsp_pkg::q_entry_t  head,
	input  tsp_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output tsp_pkg::out_item_t out_data
);
	import tsp_pkg::*;

	logic                       in_peak_q;
	logic [COUNT_W-1:0]         sample_idx_q;
	logic [COUNT_W-1:0]         start_idx_q;
	logic [COUNT_W-1:0]         end_idx_q;
	logic signed [SAMPLE_W-1:0] run_max_q;
	logic [COUNT_W-1:0]         peak_cnt_q;
	logic [ACC_W-1:0]           inj_acc_q;
	logic [ACC_W-1:0]           dis_acc_q;
	logic [ACC_W-1:0]           max_acc_q;
	logic [COUNT_W-1:0]         len_acc_q;
	logic [COUNT_W-1:0]         gap_acc_q;
	logic                       out_valid_q;
	out_item_t                  out_q;

	logic                       in_peak_d;
	logic [COUNT_W-1:0]         start_idx_d;
	logic [COUNT_W-1:0]         end_idx_d;
	logic signed [SAMPLE_W-1:0] run_max_d;
	logic [COUNT_W-1:0]         peak_cnt_d;
	logic [ACC_W-1:0]           inj_acc_d;
	logic [ACC_W-1:0]           dis_acc_d;
	logic [ACC_W-1:0]           max_acc_d;
	logic [COUNT_W-1:0]         len_acc_d;
	logic [COUNT_W-1:0]         gap_acc_d;
	logic [COUNT_W-1:0]         sample_idx_d;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] dis;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !q_status.empty && (!head.item.last || out_free);
	assign dis      = head.item.dissipation;

	always_comb begin
		in_peak_d    = in_peak_q;
		start_idx_d  = start_idx_q;
		end_idx_d    = end_idx_q;
		run_max_d    = run_max_q;
		peak_cnt_d   = peak_cnt_q;
		max_acc_d    = max_acc_q;
		len_acc_d    = len_acc_q;
		gap_acc_d    = gap_acc_q;
		sample_idx_d = sample_idx_q + COUNT_W'(1);
		inj_acc_d    = inj_acc_q + {{(ACC_W-SAMPLE_W){head.item.injection[SAMPLE_W-1]}},
			head.item.injection};
		dis_acc_d    = dis_acc_q + {{(ACC_W-SAMPLE_W){dis[SAMPLE_W-1]}}, dis};
		if (head.above) begin
			if (!in_peak_q) begin
				in_peak_d   = 1'b1;
				peak_cnt_d  = peak_cnt_q + COUNT_W'(1);
				start_idx_d = sample_idx_q;
				run_max_d   = dis;
				gap_acc_d   = gap_acc_q + (sample_idx_q - end_idx_q);
			end else if (dis > run_max_q) begin
				run_max_d = dis;
			end
		end
		if (head.below && in_peak_q) begin
			in_peak_d = 1'b0;
			end_idx_d = sample_idx_q;
			len_acc_d = len_acc_q + (sample_idx_q - start_idx_q);
			max_acc_d = max_acc_q + {{(ACC_W-SAMPLE_W){run_max_q[SAMPLE_W-1]}}, run_max_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_peak_q    <= 1'b0;
			sample_idx_q <= '0;
			start_idx_q  <= '0;
			end_idx_q    <= '0;
			run_max_q    <= '0;
			peak_cnt_q   <= '0;
			inj_acc_q    <= '0;
			dis_acc_q    <= '0;
			max_acc_q    <= '0;
			len_acc_q    <= '0;
			gap_acc_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && head.item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.item.last) begin
					in_peak_q    <= 1'b0;
					sample_idx_q <= '0;
					start_idx_q  <= '0;
					end_idx_q    <= '0;
					run_max_q    <= '0;
					peak_cnt_q   <= '0;
					inj_acc_q    <= '0;
					dis_acc_q    <= '0;
					max_acc_q    <= '0;
					len_acc_q    <= '0;
					gap_acc_q    <= '0;
				end else begin
					in_peak_q    <= in_peak_d;
					sample_idx_q <= sample_idx_d;
					start_idx_q  <= start_idx_d;
					end_idx_q    <= end_idx_d;
					run_max_q    <= run_max_d;
					peak_cnt_q   <= peak_cnt_d;
					inj_acc_q    <= inj_acc_d;
					dis_acc_q    <= dis_acc_d;
					max_acc_q    <= max_acc_d;
					len_acc_q    <= len_acc_d;
					gap_acc_q    <= gap_acc_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.item.last) begin
			out_q.sample_count    <= sample_idx_d;
			out_q.peak_count      <= peak_cnt_d;
			out_q.injection_sum   <= inj_acc_d;
			out_q.dissipation_sum <= dis_acc_d;
			out_q.peak_max_sum    <= max_acc_d;
			out_q.peak_length_sum <= len_acc_d;
			out_q.peak_gap_sum    <= gap_acc_d;
			out_q.still_in_peak   <= in_peak_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/threshold_peak_statistics.sv
// ----------------------------------------------------------------------------
// Threshold peak statistics
// Usage: each input request carries an injection and a dissipation sample in
// signed Q11.12 and a last flag. A peak opens when dissipation rises above the
// threshold register and closes when it falls strictly below it. On a request
// with last set, one result with the record totals is issued and all
// statistics are cleared; the threshold is kept.
// Channels use valid and stall; a request moves on a rising edge with valid
// high and stall low. The threshold is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
// out_valid rises once the last request has passed the queue and the output
// register, later while an earlier result is still held in that register.
// One request per cycle enters while the queue is not full.
// A four-entry queue separates the classifying front end from the back end.
// When the receiver stalls, the result is held and requests keep flowing until
// a further last request reaches the head of the queue and the queue fills.
// Reset clears the threshold, the queue and all statistics.
// ----------------------------------------------------------------------------
module threshold_peak_statistics (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic signed [tsp_pkg::SAMPLE_W-1:0] cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tsp_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tsp_pkg::out_item_t                  out_data
);
	import tsp_pkg::*;

	q_status_t q_status;
	q_entry_t  push_data;
	q_entry_t  head;
	logic      push;
	logic      pop;

	tsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.q_status   (q_status),
		.push       (push),
		.push_data  (push_data)
	);

	tsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	tsp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

FILE: tb/tb_threshold_peak_statistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold peak statistics testbench
// Drives sample requests through the peak statistics block and checks every
// record total against a predictor kept inside the bench. A short table of
// hand-made requests comes first; random records follow under three idling
// patterns and several threshold settings. A long receiver hold-off fills the
// block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_threshold_peak_statistics;
	import tsp_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int LATENCY_PAUSE = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int SEGMENT_ITEMS = 120;
	localparam int REPORT_LIMIT  = 10;
	localparam int MAX_GAP       = 20;
	localparam int SMP_MAX       = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SMP_MIN       = -(1 << (SAMPLE_W - 1));

	typedef enum logic {
		ROW_SAMPLE,
		ROW_THRESHOLD
	} row_kind_t;

	typedef struct {
		row_kind_t                  kind;
		in_item_t                   smp;
		logic signed [SAMPLE_W-1:0] thr;
		bit                         typed;
		out_item_t                  want;
	} plan_row_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_wr_en   = 1'b0;
	logic signed [SAMPLE_W-1:0] cfg_wr_data = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	in_item_t                   in_data     = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	out_item_t                  out_data;

	// Predictor state.
	logic signed [SAMPLE_W-1:0] thr_cur;
	logic                       pk_open;
	logic [COUNT_W-1:0]         pk_idx;
	logic [COUNT_W-1:0]         pk_start;
	logic [COUNT_W-1:0]         pk_end;
	logic signed [SAMPLE_W-1:0] pk_max;
	logic [COUNT_W-1:0]         pk_num;
	logic signed [ACC_W-1:0]    inj_total;
	logic signed [ACC_W-1:0]    dis_total;
	logic signed [ACC_W-1:0]    max_total;
	logic [COUNT_W-1:0]         len_total;
	logic [COUNT_W-1:0]         gap_total;

	out_item_t totals_q[$];
	plan_row_t plan[$];

	int snd_idle_pct    = 0;
	int rcv_idle_pct    = 0;
	int hold_seq        = 0;
	int hold_seen       = 0;
	int hold_left       = 0;
	int cycles          = 0;
	int mismatches      = 0;
	int items_sent      = 0;
	int results_seen    = 0;
	int in_stall_cycles = 0;
	int thr_writes      = 0;

	threshold_peak_statistics dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [ACC_W-1:0] widen(input logic signed [SAMPLE_W-1:0] v);
		return {{(ACC_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	task automatic clear_peak_stats();
		pk_open   = 1'b0;
		pk_idx    = '0;
		pk_start  = '0;
		pk_end    = '0;
		pk_max    = '0;
		pk_num    = '0;
		inj_total = '0;
		dis_total = '0;
		max_total = '0;
		len_total = '0;
		gap_total = '0;
	endtask

	task automatic peak_stats_apply(input in_item_t s, output bit emit, output out_item_t r);
		logic [COUNT_W-1:0]         idx;
		logic signed [SAMPLE_W-1:0] dis;
		idx = pk_idx;
		dis = s.dissipation;
		inj_total = inj_total + widen(s.injection);
		dis_total = dis_total + widen(dis);
		if ($signed(dis) > $signed(thr_cur)) begin
			if (!pk_open) begin
				pk_open   = 1'b1;
				pk_num    = pk_num + COUNT_W'(1);
				pk_start  = idx;
				pk_max    = dis;
				gap_total = gap_total + (idx - pk_end);
			end else if ($signed(dis) > $signed(pk_max)) begin
				pk_max = dis;
			end
		end
		if ($signed(dis) < $signed(thr_cur) && pk_open) begin
			pk_open   = 1'b0;
			pk_end    = idx;
			len_total = len_total + (idx - pk_start);
			max_total = max_total + widen(pk_max);
		end
		pk_idx = idx + COUNT_W'(1);
		emit = s.last;
		r = '0;
		if (s.last) begin
			r.sample_count    = pk_idx;
			r.peak_count      = pk_num;
			r.injection_sum   = inj_total;
			r.dissipation_sum = dis_total;
			r.peak_max_sum    = max_total;
			r.peak_length_sum = len_total;
			r.peak_gap_sum    = gap_total;
			r.still_in_peak   = pk_open;
			clear_peak_stats();
		end
	endtask

	function automatic out_item_t totals_of(input int cnt, pk, inj, dis, pmax, len, gap,
			input bit left_open);
		out_item_t r;
		r.sample_count    = COUNT_W'(cnt);
		r.peak_count      = COUNT_W'(pk);
		r.injection_sum   = ACC_W'(inj);
		r.dissipation_sum = ACC_W'(dis);
		r.peak_max_sum    = ACC_W'(pmax);
		r.peak_length_sum = COUNT_W'(len);
		r.peak_gap_sum    = COUNT_W'(gap);
		r.still_in_peak   = left_open;
		return r;
	endfunction

	function automatic plan_row_t sample_row(input int inj, dis, input bit fin);
		plan_row_t r;
		r.kind            = ROW_SAMPLE;
		r.smp.injection   = SAMPLE_W'(inj);
		r.smp.dissipation = SAMPLE_W'(dis);
		r.smp.last        = fin;
		r.thr             = '0;
		r.typed           = 1'b0;
		r.want            = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input int inj, dis, input bit fin,
			input out_item_t want);
		plan_row_t r;
		r       = sample_row(inj, dis, fin);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t threshold_row(input int v);
		plan_row_t r;
		r      = sample_row(0, 0, 1'b0);
		r.kind = ROW_THRESHOLD;
		r.thr  = SAMPLE_W'(v);
		return r;
	endfunction

	task automatic note_field(input string field, input logic [ACC_W-1:0] want,
			input logic [ACC_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("Result %0d, %s: expected %h, got %h", results_seen, field, want, got);
			end
		end
	endtask

	task automatic check_totals(input out_item_t got);
		out_item_t want;
		if (totals_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("Result with no record pending: %p", got);
			end
			return;
		end
		want = totals_q.pop_front();
		results_seen++;
		note_field("sample_count", ACC_W'(want.sample_count), ACC_W'(got.sample_count));
		note_field("peak_count", ACC_W'(want.peak_count), ACC_W'(got.peak_count));
		note_field("injection_sum", want.injection_sum, got.injection_sum);
		note_field("dissipation_sum", want.dissipation_sum, got.dissipation_sum);
		note_field("peak_max_sum", want.peak_max_sum, got.peak_max_sum);
		note_field("peak_length_sum", ACC_W'(want.peak_length_sum),
			ACC_W'(got.peak_length_sum));
		note_field("peak_gap_sum", ACC_W'(want.peak_gap_sum), ACC_W'(got.peak_gap_sum));
		note_field("still_in_peak", ACC_W'(want.still_in_peak), ACC_W'(got.still_in_peak));
	endtask

	task automatic push_sample(input in_item_t s, input bit typed, input out_item_t want);
		int        gap;
		bit        emit;
		out_item_t r;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct && gap < MAX_GAP) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		peak_stats_apply(s, emit, r);
		if (emit) begin
			totals_q.push_back(typed ? want : r);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (totals_q.size() != 0) @(posedge clk);
		repeat (LATENCY_PAUSE) @(posedge clk);
	endtask

	task automatic write_threshold(input logic signed [SAMPLE_W-1:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		thr_cur = v;
		thr_writes++;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_record(input int len);
		in_item_t  s;
		out_item_t none;
		int        t;
		int        dis;
		int        pick;
		none = '0;
		t    = thr_cur;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(7);
			if (pick == 0) begin
				s.injection = SAMPLE_W'(SMP_MAX);
			end else if (pick == 1) begin
				s.injection = SAMPLE_W'(SMP_MIN);
			end else begin
				s.injection = SAMPLE_W'($urandom);
			end
			pick = $urandom_range(9);
			if (pick < 6) begin
				dis = t + int'($urandom_range(8)) - 4;
				if (dis > SMP_MAX) dis = SMP_MAX;
				if (dis < SMP_MIN) dis = SMP_MIN;
				s.dissipation = SAMPLE_W'(dis);
			end else if (pick < 8) begin
				s.dissipation = SAMPLE_W'($urandom);
			end else if (pick == 8) begin
				s.dissipation = SAMPLE_W'(SMP_MIN);
			end else begin
				s.dissipation = SAMPLE_W'(SMP_MAX);
			end
			s.last = (i == len - 1);
			push_sample(s, 1'b0, none);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			check_totals(out_data);
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (in_valid && in_stall) in_stall_cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic signed [SAMPLE_W-1:0] thr;
		int                         seg_start;
		int                         len;
		thr_cur = '0;
		clear_peak_stats();

		// Single-sample records at the extremes, one with the peak left open.
		plan.push_back(typed_row(SMP_MAX, 0, 1'b1,
			totals_of(1, 0, SMP_MAX, 0, 0, 0, 0, 1'b0)));
		plan.push_back(typed_row(SMP_MIN, SMP_MIN, 1'b1,
			totals_of(1, 0, SMP_MIN, SMP_MIN, 0, 0, 0, 1'b0)));
		plan.push_back(typed_row(0, SMP_MAX, 1'b1,
			totals_of(1, 1, 0, SMP_MAX, 0, 0, 0, 1'b1)));
		// Two peaks with a rising maximum, a level equal to the threshold and a gap.
		plan.push_back(sample_row(100, 50, 1'b0));
		plan.push_back(sample_row(-5, 200, 1'b0));
		plan.push_back(sample_row(7, 0, 1'b0));
		plan.push_back(sample_row(1, 150, 1'b0));
		plan.push_back(sample_row(2, -1, 1'b0));
		plan.push_back(sample_row(3, 0, 1'b0));
		plan.push_back(sample_row(4, 1, 1'b0));
		plan.push_back(sample_row(5, SMP_MIN, 1'b1));
		plan.push_back(threshold_row(SMP_MAX));
		plan.push_back(sample_row(1, SMP_MAX, 1'b0));
		plan.push_back(typed_row(-1, SMP_MIN, 1'b1, totals_of(2, 0, 0, -1, 0, 0, 0, 1'b0)));
		plan.push_back(threshold_row(SMP_MIN));
		plan.push_back(sample_row(0, SMP_MIN, 1'b0));
		plan.push_back(sample_row(0, SMP_MIN + 1, 1'b0));
		plan.push_back(typed_row(0, SMP_MAX, 1'b1,
			totals_of(3, 1, 0, SMP_MIN, 0, 0, 1, 1'b1)));
		plan.push_back(threshold_row(0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_THRESHOLD) begin
				write_threshold(plan[i].thr);
			end else begin
				push_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					snd_idle_pct = 34;
					rcv_idle_pct = 52;
				end
				1: begin
					snd_idle_pct = 52;
					rcv_idle_pct = 34;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				case (seg)
					0: thr = SAMPLE_W'($urandom);
					1: thr = SAMPLE_W'(int'($urandom_range(8192)) - 4096);
					2: thr = (phase == 0) ? SAMPLE_W'(SMP_MAX) :
						(phase == 1) ? SAMPLE_W'(SMP_MIN) : '0;
					default: thr = SAMPLE_W'(int'($urandom_range(256)) - 128);
				endcase
				write_threshold(thr);
				seg_start = items_sent;
				while (items_sent - seg_start < SEGMENT_ITEMS) begin
					if ($urandom_range(9) == 0) begin
						len = $urandom_range(120, 40);
					end else begin
						len = $urandom_range(16, 1);
					end
					send_record(len);
				end
			end
		end

		// Short records while the receiver holds off, so that the block fills up.
		wait_idle();
		hold_seq++;
		repeat (30) send_record($urandom_range(3, 1));
		wait_idle();

		$display("Sent %0d sample requests, checked %0d record totals, %0d threshold writes.",
			items_sent, results_seen, thr_writes);
		$display("Input was stalled for %0d cycles, including one %0d-cycle receiver hold-off.",
			in_stall_cycles, HOLD_CYCLES);
		if (mismatches == 0 && totals_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_front.sv
hw/rtl/tsp_queue.sv
hw/rtl/tsp_back.sv
hw/rtl/threshold_peak_statistics.sv
tb/tb_threshold_peak_statistics.sv
